// ===== rtl/adhv_pkg.sv =====
// ----------------------------------------------------------------------------
// Additive harmonic voice package
// Shared widths, types, microcode program and sine table for the voice.
// ----------------------------------------------------------------------------
package adhv_pkg;

  localparam int PHASE_BITS     = 24;
  localparam int DUR_BITS       = 24;
  localparam int SINE_DEPTH     = 1024;
  localparam int HARMONIC_COUNT = 6;

  localparam int ADDR_W  = $clog2(SINE_DEPTH);
  localparam int HM_W    = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
  localparam int DECAY_W = 24;
  localparam int GAIN_W  = 16;
  localparam int ENV_W   = 25;
  localparam int SINE_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int SUM_W   = 24;
  localparam int X_W     = 24;
  localparam int TONE_W  = 25;
  localparam int Y_W     = 27;
  localparam int MUL_W   = 28;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int IN_DATA_W  = PHASE_BITS + DECAY_W + GAIN_W + DUR_BITS;
  localparam int OUT_DATA_W = SAMPLE_W;
  localparam int ENTRY_SHIFT = 5;

  typedef logic [PHASE_BITS-1:0]      phase_t;
  typedef logic [DUR_BITS-1:0]        dur_t;
  typedef logic [HM_W-1:0]            hm_t;
  typedef logic [ENV_W-1:0]           env_t;
  typedef logic signed [SINE_W-1:0]   sine_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [X_W-1:0]      x_t;
  typedef logic signed [TONE_W-1:0]   tone_t;
  typedef logic signed [Y_W-1:0]      y_t;
  typedef logic signed [MUL_W-1:0]    mop_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef sine_t sine_tab_t [SINE_DEPTH];

  localparam hm_t     HM_LAST    = hm_t'(HARMONIC_COUNT - 1);
  localparam env_t    ENV_ONE    = env_t'(1 << 24);
  localparam y_t      Y_POS_ONE  = y_t'(1 << 20);
  localparam y_t      Y_NEG_ONE  = -Y_POS_ONE;
  localparam sample_t SAMPLE_MAX = sample_t'(32767);
  localparam mop_t    FULL_SCALE = mop_t'(32767);

  typedef struct packed {
    dur_t                duration_samples;
    logic [GAIN_W-1:0]   loudness;
    logic [DECAY_W-1:0]  decay_factor;
    phase_t              phase_step;
  } note_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_LATCH,
    OP_INIT,
    OP_ACC,
    OP_MUL_SE,
    OP_MUL_XX,
    OP_MUL_SQX,
    OP_TONE,
    OP_MUL_TG,
    OP_MUL_ED,
    OP_MUL_Y,
    OP_EMIT,
    OP_EMIT_IDLE
  } uop_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_WAIT_IN,
    C_SILENT,
    C_LOOP_H,
    C_WAIT_OUT
  } cond_t;

  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;

  localparam step_t ST_WAIT     = step_t'(0);
  localparam step_t ST_INIT     = step_t'(1);
  localparam step_t ST_FETCH    = step_t'(2);
  localparam step_t ST_ACC      = step_t'(3);
  localparam step_t ST_MSE      = step_t'(4);
  localparam step_t ST_MXX      = step_t'(5);
  localparam step_t ST_MSQX     = step_t'(6);
  localparam step_t ST_TONE     = step_t'(7);
  localparam step_t ST_MTG      = step_t'(8);
  localparam step_t ST_MED      = step_t'(9);
  localparam step_t ST_MY       = step_t'(10);
  localparam step_t ST_EMIT     = step_t'(11);
  localparam step_t ST_IDLE_OUT = step_t'(12);

  typedef struct packed {
    uop_t  op;
    cond_t cond;
    step_t target;
  } ucode_t;

  typedef struct packed {
    uop_t op;
    logic fire;
  } ctl_t;

  typedef struct packed {
    logic silent;
    logic last_h;
  } stat_t;

  typedef struct packed {
    logic    valid;
    sample_t sample;
    logic    active;
  } res_t;

  function automatic ucode_t ucode_at(step_t s);
    ucode_t u;
    case (s)
      ST_WAIT:     u = '{OP_LATCH,     C_WAIT_IN,  ST_WAIT};
      ST_INIT:     u = '{OP_INIT,      C_SILENT,   ST_IDLE_OUT};
      ST_FETCH:    u = '{OP_NOP,       C_NEXT,     ST_WAIT};
      ST_ACC:      u = '{OP_ACC,       C_LOOP_H,   ST_FETCH};
      ST_MSE:      u = '{OP_MUL_SE,    C_NEXT,     ST_WAIT};
      ST_MXX:      u = '{OP_MUL_XX,    C_NEXT,     ST_WAIT};
      ST_MSQX:     u = '{OP_MUL_SQX,   C_NEXT,     ST_WAIT};
      ST_TONE:     u = '{OP_TONE,      C_NEXT,     ST_WAIT};
      ST_MTG:      u = '{OP_MUL_TG,    C_NEXT,     ST_WAIT};
      ST_MED:      u = '{OP_MUL_ED,    C_NEXT,     ST_WAIT};
      ST_MY:       u = '{OP_MUL_Y,     C_NEXT,     ST_WAIT};
      ST_EMIT:     u = '{OP_EMIT,      C_WAIT_OUT, ST_WAIT};
      ST_IDLE_OUT: u = '{OP_EMIT_IDLE, C_WAIT_OUT, ST_WAIT};
      default:     u = '{OP_NOP,       C_JUMP,     ST_WAIT};
    endcase
    return u;
  endfunction

  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Each entry is a Horner evaluation of the sine series on the folded angle.
  function automatic sine_tab_t build_sine();
    sine_tab_t   t;
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] r;
    logic        neg;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      th  = (64'(i) * TWO_PI_Q30) / SINE_DEPTH;
      neg = 1'b0;
      if (th >= PI_Q30) begin
        neg = 1'b1;
        th  = th - PI_Q30;
      end
      if (th > HALF_PI_Q30) begin
        th = PI_Q30 - th;
      end
      x2 = (th * th) >> 30;
      s  = ONE_Q30;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 110;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 72;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 42;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 20;
      s  = ONE_Q30 - ((x2 * s) >> 30) / 6;
      r  = (th * s) >> 30;
      r  = (r + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      t[i] = neg ? -sine_t'(r) : sine_t'(r);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

endpackage

// ===== rtl/adhv_sine_rom.sv =====
// ----------------------------------------------------------------------------
// Sine table ROM
// One full period of Q1.15 sine values with a registered read port.
// ----------------------------------------------------------------------------
module adhv_sine_rom (
  input  logic                        clk,
  input  logic [adhv_pkg::ADDR_W-1:0] rd_addr,
  output adhv_pkg::sine_t             rd_data
);

  adhv_pkg::sine_t rd_data_r;

  always_ff @(posedge clk) begin
    rd_data_r <= adhv_pkg::SINE_TAB[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/adhv_seq.sv =====
// ----------------------------------------------------------------------------
// Microcode sequencer
// Step counter over the control program, with waits and conditional jumps.
// ----------------------------------------------------------------------------
module adhv_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  input  adhv_pkg::stat_t   stat,
  output adhv_pkg::ctl_t    ctl,
  output logic              in_ready
);

  adhv_pkg::step_t  step_r;
  adhv_pkg::step_t  step_nxt;
  adhv_pkg::step_t  step_inc;
  adhv_pkg::ucode_t uw;

  assign uw       = adhv_pkg::ucode_at(step_r);
  assign step_inc = adhv_pkg::step_t'(step_r + 1'b1);
  assign in_ready = (step_r == adhv_pkg::ST_WAIT);

  always_comb begin
    step_nxt = step_r;
    ctl.op   = uw.op;
    ctl.fire = 1'b1;
    case (uw.cond)
      adhv_pkg::C_NEXT: begin
        step_nxt = step_inc;
      end
      adhv_pkg::C_JUMP: begin
        step_nxt = uw.target;
      end
      adhv_pkg::C_WAIT_IN: begin
        ctl.fire = in_valid;
        step_nxt = in_valid ? step_inc : step_r;
      end
      adhv_pkg::C_SILENT: begin
        step_nxt = stat.silent ? uw.target : step_inc;
      end
      adhv_pkg::C_LOOP_H: begin
        step_nxt = stat.last_h ? step_inc : uw.target;
      end
      adhv_pkg::C_WAIT_OUT: begin
        ctl.fire = out_free;
        step_nxt = out_free ? uw.target : step_r;
      end
      default: begin
        step_nxt = adhv_pkg::ST_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= adhv_pkg::ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/adhv_dp.sv =====
// ----------------------------------------------------------------------------
// Voice datapath
// Note registers, harmonic accumulator and one shared registered multiplier.
// ----------------------------------------------------------------------------
module adhv_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  adhv_pkg::ctl_t              ctl,
  input  logic                        note_start,
  input  adhv_pkg::note_t             note,
  input  adhv_pkg::sine_t             rom_data,
  output logic [adhv_pkg::ADDR_W-1:0] rom_addr,
  output adhv_pkg::stat_t             stat,
  output adhv_pkg::res_t              res
);

  adhv_pkg::phase_t               phase_r, phase_nxt;
  adhv_pkg::phase_t               hp_r, hp_nxt;
  adhv_pkg::phase_t               step_r, step_nxt;
  adhv_pkg::dur_t                 left_r, left_nxt;
  logic [adhv_pkg::DECAY_W-1:0]   decay_r, decay_nxt;
  logic [adhv_pkg::GAIN_W-1:0]    gain_r, gain_nxt;
  adhv_pkg::env_t                 env_r, env_nxt;
  adhv_pkg::hm_t                  hm_r, hm_nxt;
  adhv_pkg::sum_t                 sum_r, sum_nxt;
  adhv_pkg::x_t                   x_r, x_nxt;
  adhv_pkg::tone_t                tone_r, tone_nxt;
  adhv_pkg::y_t                   y_r, y_nxt;
  adhv_pkg::prod_t                prod_r;
  adhv_pkg::mop_t                 mul_a, mul_b;
  adhv_pkg::sum_t                 ent_q20, term;
  adhv_pkg::x_t                   p_q24, p_q20;
  adhv_pkg::y_t                   p_q15;
  adhv_pkg::mop_t                 y_ext, y_abs;
  logic [14:0]                    mag;
  adhv_pkg::sample_t              smp;

  assign rom_addr = hp_r[adhv_pkg::PHASE_BITS-1 -: adhv_pkg::ADDR_W];
  assign stat.silent = (left_r == '0);
  assign stat.last_h = (hm_r == adhv_pkg::HM_LAST);

  assign ent_q20 = adhv_pkg::sum_t'(rom_data) <<< adhv_pkg::ENTRY_SHIFT;
  assign term    = ent_q20 >>> hm_r;
  assign p_q24   = prod_r[47:24];
  assign p_q20   = prod_r[43:20];
  assign p_q15   = prod_r[41:15];
  assign y_ext   = adhv_pkg::mop_t'(y_r);
  assign y_abs   = y_r[adhv_pkg::Y_W-1] ? -y_ext : y_ext;
  assign mag     = prod_r[34:20];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      adhv_pkg::OP_MUL_SE: begin
        mul_a = adhv_pkg::mop_t'(sum_r);
        mul_b = adhv_pkg::mop_t'(env_r);
      end
      adhv_pkg::OP_MUL_XX: begin
        mul_a = adhv_pkg::mop_t'(p_q24);
        mul_b = adhv_pkg::mop_t'(p_q24);
      end
      adhv_pkg::OP_MUL_SQX: begin
        mul_a = adhv_pkg::mop_t'(p_q20);
        mul_b = adhv_pkg::mop_t'(x_r);
      end
      adhv_pkg::OP_MUL_TG: begin
        mul_a = adhv_pkg::mop_t'(tone_r);
        mul_b = adhv_pkg::mop_t'(gain_r);
      end
      adhv_pkg::OP_MUL_ED: begin
        mul_a = adhv_pkg::mop_t'(env_r);
        mul_b = adhv_pkg::mop_t'(decay_r);
      end
      adhv_pkg::OP_MUL_Y, adhv_pkg::OP_EMIT: begin
        mul_a = y_abs;
        mul_b = adhv_pkg::FULL_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    if (y_r > adhv_pkg::Y_POS_ONE) begin
      smp = adhv_pkg::SAMPLE_MAX;
    end else if (y_r < adhv_pkg::Y_NEG_ONE) begin
      smp = -adhv_pkg::SAMPLE_MAX;
    end else if (y_r[adhv_pkg::Y_W-1]) begin
      smp = -adhv_pkg::sample_t'(mag);
    end else begin
      smp = adhv_pkg::sample_t'(mag);
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    hp_nxt    = hp_r;
    step_nxt  = step_r;
    left_nxt  = left_r;
    decay_nxt = decay_r;
    gain_nxt  = gain_r;
    env_nxt   = env_r;
    hm_nxt    = hm_r;
    sum_nxt   = sum_r;
    x_nxt     = x_r;
    tone_nxt  = tone_r;
    y_nxt     = y_r;
    res.valid  = 1'b0;
    res.sample = '0;
    res.active = 1'b0;
    case (ctl.op)
      adhv_pkg::OP_LATCH: begin
        if (ctl.fire && note_start) begin
          step_nxt  = note.phase_step;
          decay_nxt = note.decay_factor;
          gain_nxt  = note.loudness;
          left_nxt  = note.duration_samples;
          phase_nxt = '0;
          env_nxt   = adhv_pkg::ENV_ONE;
        end
      end
      adhv_pkg::OP_INIT: begin
        sum_nxt = '0;
        hp_nxt  = phase_r;
        hm_nxt  = '0;
      end
      adhv_pkg::OP_ACC: begin
        sum_nxt = sum_r + term;
        hp_nxt  = hp_r + phase_r;
        hm_nxt  = adhv_pkg::hm_t'(hm_r + 1'b1);
      end
      adhv_pkg::OP_MUL_XX: begin
        x_nxt = p_q24;
      end
      adhv_pkg::OP_TONE: begin
        tone_nxt = adhv_pkg::tone_t'(x_r) + adhv_pkg::tone_t'(p_q20);
      end
      adhv_pkg::OP_MUL_ED: begin
        y_nxt = p_q15;
      end
      adhv_pkg::OP_MUL_Y: begin
        env_nxt = prod_r[48:24];
      end
      adhv_pkg::OP_EMIT: begin
        res.valid  = ctl.fire;
        res.sample = smp;
        res.active = 1'b1;
        if (ctl.fire) begin
          phase_nxt = phase_r + step_r;
          left_nxt  = left_r - 1'b1;
        end
      end
      adhv_pkg::OP_EMIT_IDLE: begin
        res.valid = ctl.fire;
      end
      default: begin
        res.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    hp_r    <= hp_nxt;
    step_r  <= step_nxt;
    decay_r <= decay_nxt;
    gain_r  <= gain_nxt;
    env_r   <= env_nxt;
    hm_r    <= hm_nxt;
    sum_r   <= sum_nxt;
    x_r     <= x_nxt;
    tone_r  <= tone_nxt;
    y_r     <= y_nxt;
    prod_r  <= adhv_pkg::prod_t'(mul_a) * adhv_pkg::prod_t'(mul_b);
  end

endmodule

// ===== rtl/additive_decaying_harmonic_voice_top.sv =====
// ----------------------------------------------------------------------------
// Additive decaying harmonic voice
// One request in gives one 16-bit audio sample out, six decaying harmonics.
// ----------------------------------------------------------------------------
// The input channel carries one request per audio sample tick. in_tuser set
// marks a note start; the request then loads step, decay, loudness and
// length, and is itself the first sample of the note.
// The output channel returns one request per input request: the sample in
// out_tdata and, in out_tuser, whether it belongs to a sounding note.
// A sounding sample is loaded into the output register after one setup step,
// a fetch and an accumulate step per harmonic on the registered sine table,
// and eight more steps that run the single shared multiplier and emit. A
// silent sample is loaded after the setup step and an idle output step. One
// request is in work at a time: a new request is taken only once the last
// one's sample has been emitted.
// The result sits in an output register; the next input request is taken
// while it waits, and the sequencer holds at its output step only when that
// register is still full. Reset returns the sequencer to its wait step,
// empties the output register and ends any sounding note.
// ----------------------------------------------------------------------------
module additive_decaying_harmonic_voice_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // phase_step[23:0], decay_factor[47:24], loudness[63:48],
  // duration_samples[87:64]
  input  logic [adhv_pkg::IN_DATA_W-1:0]      in_tdata,
  // note_start
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // sample[15:0]
  output logic [adhv_pkg::OUT_DATA_W-1:0]     out_tdata,
  // active
  output logic                                out_tuser
);

  adhv_pkg::ctl_t                ctl;
  adhv_pkg::stat_t               stat;
  adhv_pkg::res_t                res;
  adhv_pkg::note_t               note;
  adhv_pkg::sine_t               rom_data;
  logic [adhv_pkg::ADDR_W-1:0]   rom_addr;
  logic                          out_free;
  logic                          out_valid_r, out_valid_nxt;
  adhv_pkg::sample_t             out_sample_r, out_sample_nxt;
  logic                          out_active_r, out_active_nxt;

  assign note     = adhv_pkg::note_t'(in_tdata);
  assign out_free = !out_valid_r || out_tready;

  adhv_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .in_ready (in_tready)
  );

  adhv_sine_rom u_rom (
    .clk     (clk),
    .rd_addr (rom_addr),
    .rd_data (rom_data)
  );

  adhv_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .note_start (in_tuser),
    .note       (note),
    .rom_data   (rom_data),
    .rom_addr   (rom_addr),
    .stat       (stat),
    .res        (res)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_active_nxt = out_active_r;
    if (res.valid) begin
      out_valid_nxt  = 1'b1;
      out_sample_nxt = res.sample;
      out_active_nxt = res.active;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_sample_r <= out_sample_nxt;
    out_active_r <= out_active_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tuser  = out_active_r;

endmodule

// ===== sim/additive_decaying_harmonic_voice_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Additive decaying harmonic voice testbench
// Streams sample ticks into the voice and checks every returned sample
// against an in-bench model of the six-harmonic decaying tone.
// ----------------------------------------------------------------------------
// A short table of directed ticks covers idle ticks, zero length notes,
// zero phase, half and quarter turns, restarts, zero decay, zero and maximum
// loudness and the largest length. Random notes with random content follow,
// mixed with stray ticks and broken notes. Both channels idle in random
// bursts, and the input side drains once before sending more.
// ----------------------------------------------------------------------------
module additive_decaying_harmonic_voice_top_tb;
  import adhv_pkg::*;

  localparam int RANDOM_ITEMS = 1050;
  localparam int CALM_TAIL    = 100;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    bit                 start;
    logic [23:0]        step;
    logic [23:0]        decay;
    logic [15:0]        gain;
    logic [23:0]        dur;
    bit                 typed;
    sample_t            smp;
    bit                 act;
  } tick_row_t;

  typedef struct packed {
    sample_t smp;
    logic    act;
  } voice_out_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  additive_decaying_harmonic_voice_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Model state of the voice.
  logic [23:0] tone_phase;
  logic [24:0] tone_env;
  logic [23:0] tone_left;
  logic [23:0] tone_step;
  logic [23:0] tone_decay;
  logic [15:0] tone_gain;
  longint      sine_rom [SINE_DEPTH];

  voice_out_t  pending_samples [$];
  tick_row_t   directed_ticks [$];

  int  n_items;
  int  n_checked;
  int  n_sounding;
  int  n_clipped;
  int  n_starts;
  int  n_errors;
  bit  calm;
  int  stall_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d samples still awaited", pending_samples.size());
    $display("Mismatches found");
    $finish;
  end

  function automatic longint horner_sine(int idx);
    logic [63:0] th;
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] r;
    bit          neg;
    th  = (64'(idx) * 64'd6746518852) / SINE_DEPTH;
    neg = 1'b0;
    if (th >= 64'd3373259426) begin
      neg = 1'b1;
      th  = th - 64'd3373259426;
    end
    if (th > 64'd1686629713) begin
      th = 64'd3373259426 - th;
    end
    x2 = (th * th) >> 30;
    s  = 64'd1073741824;
    s  = 64'd1073741824 - ((x2 * s) >> 30) / 110;
    s  = 64'd1073741824 - ((x2 * s) >> 30) / 72;
    s  = 64'd1073741824 - ((x2 * s) >> 30) / 42;
    s  = 64'd1073741824 - ((x2 * s) >> 30) / 20;
    s  = 64'd1073741824 - ((x2 * s) >> 30) / 6;
    r  = (th * s) >> 30;
    r  = (r + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Advances the voice by one sample tick and returns the sample it yields.
  function automatic voice_out_t synth_tick(tick_row_t r);
    voice_out_t  o;
    longint      sum;
    longint      x;
    longint      y;
    longint      mag;
    logic [23:0] hp;
    logic [49:0] env_prod;
    o = '0;
    if (r.start) begin
      tone_step  = r.step;
      tone_decay = r.decay;
      tone_gain  = r.gain;
      tone_left  = r.dur;
      tone_phase = '0;
      tone_env   = 25'd16777216;
    end
    if (tone_left != 0) begin
      o.act = 1'b1;
      sum = 0;
      for (int h = 1; h <= HARMONIC_COUNT; h++) begin
        hp  = 24'(h * tone_phase);
        sum = sum + ((sine_rom[hp[23:14]] * 32) >>> (h - 1));
      end
      x = (sum * longint'(tone_env)) >>> 24;
      x = x + ((((x * x) >>> 20) * x) >>> 20);
      y = (x * longint'(tone_gain)) >>> 15;
      if (y > 1048576) begin
        o.smp = 16'sd32767;
      end else if (y < -1048576) begin
        o.smp = -16'sd32767;
      end else begin
        mag   = ((y < 0 ? -y : y) * 32767) >>> 20;
        o.smp = sample_t'(y < 0 ? -mag : mag);
      end
      env_prod   = 50'(tone_env) * 50'(tone_decay);
      tone_env   = env_prod[48:24];
      tone_phase = tone_phase + tone_step;
      tone_left  = tone_left - 1'b1;
    end
    return o;
  endfunction

  function automatic tick_row_t make_row(bit start, logic [23:0] step, logic [23:0] decay,
                                         logic [15:0] gain, logic [23:0] dur, bit typed,
                                         sample_t smp, bit act);
    tick_row_t r;
    r.start = start;
    r.step  = step;
    r.decay = decay;
    r.gain  = gain;
    r.dur   = dur;
    r.typed = typed;
    r.smp   = smp;
    r.act   = act;
    return r;
  endfunction

  function automatic tick_row_t random_row(bit start);
    tick_row_t r;
    int        pick;
    r = make_row(start, 24'($urandom_range(0, 8388608)), 24'($urandom),
                 16'($urandom), 24'($urandom), 1'b0, '0, 1'b0);
    if (!start) begin
      return r;
    end
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      r.step = 24'd8388608;
    end else if (pick < 15) begin
      r.step = 24'($urandom_range(0, 4096));
    end
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.decay = 24'($urandom_range(24'hF00000, 24'hFFFFFF));
    end else if (pick < 85) begin
      r.decay = 24'($urandom_range(24'hC00000, 24'hFFFFFF));
    end else if (pick < 95) begin
      r.decay = 24'($urandom);
    end else begin
      r.decay = '0;
    end
    if ($urandom_range(0, 1) == 0) begin
      r.gain = 16'($urandom_range(0, 32768));
    end
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      r.dur = 24'($urandom_range(1, 24));
    end else if (pick < 90) begin
      r.dur = 24'($urandom_range(25, 60));
    end else if (pick < 95) begin
      r.dur = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int idx, int got, int want);
    n_errors++;
    $display("Sample %0d: %s is %0d, expected %0d", idx, what, got, want);
  endtask

  task automatic send_request(tick_row_t r);
    voice_out_t o;
    note_t      note;
    @(negedge clk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    note.phase_step       = r.step;
    note.decay_factor     = r.decay;
    note.loudness         = r.gain;
    note.duration_samples = r.dur;
    in_tvalid <= 1'b1;
    in_tdata  <= note;
    in_tuser  <= r.start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    o = synth_tick(r);
    if (r.typed) begin
      o.smp = r.smp;
      o.act = r.act;
    end
    pending_samples.push_back(o);
    n_items++;
    if (r.start) begin
      n_starts++;
    end
  endtask

  task automatic drain_voice();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(negedge clk);
  endtask

  // Result side: random stall bursts, no new ones once the run has calmed down.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 7);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_samples
    voice_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_samples.size() == 0) begin
        flag_mismatch("unexpected sample", n_checked, int'(sample_t'(out_tdata)), 0);
      end else begin
        want = pending_samples.pop_front();
        if (sample_t'(out_tdata) != want.smp) begin
          flag_mismatch("sample", n_checked, int'(sample_t'(out_tdata)), int'(want.smp));
        end
        if (out_tuser != want.act) begin
          flag_mismatch("active", n_checked, int'(out_tuser), int'(want.act));
        end
        if (want.act) begin
          n_sounding++;
        end
        if (want.smp == 16'sd32767 || want.smp == -16'sd32767) begin
          n_clipped++;
        end
      end
      n_checked++;
    end
  end

  initial begin
    tick_row_t r;
    int        kind;
    int        ticks;
    bit        drained;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    out_tready = 1'b1;
    stall_left = 0;
    calm       = 1'b0;
    drained    = 1'b0;
    n_items    = 0;
    n_checked  = 0;
    n_sounding = 0;
    n_clipped  = 0;
    n_starts   = 0;
    n_errors   = 0;
    tone_phase = '0;
    tone_env   = '0;
    tone_left  = '0;
    tone_step  = '0;
    tone_decay = '0;
    tone_gain  = '0;
    for (int i = 0; i < SINE_DEPTH; i++) begin
      sine_rom[i] = horner_sine(i);
    end

    // Idle ticks, zero length, zero phase, half and quarter turns.
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 0));
    directed_ticks.push_back(make_row(0, 24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF,
                                      1, 0, 0));
    directed_ticks.push_back(make_row(1, 24'd4194304, 24'hFFFFFF, 16'hFFFF, 0, 1, 0, 0));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 0));
    directed_ticks.push_back(make_row(1, 0, 24'hFFFFFF, 16'hFFFF, 2, 1, 0, 1));
    directed_ticks.push_back(make_row(0, 24'h123456, 24'h654321, 16'hABCD, 24'h0F0F0F,
                                      1, 0, 1));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 0));
    directed_ticks.push_back(make_row(1, 24'd4194304, 24'hFFFFFF, 16'hFFFF, 3, 1, 0, 1));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0));
    directed_ticks.push_back(make_row(1, 24'd8388608, 24'hFFFFFF, 16'hFFFF, 5, 1, 0, 1));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 1));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 1));
    // Restart with zero decay and the longest length.
    directed_ticks.push_back(make_row(1, 24'd1398101, 0, 16'd32768, 24'hFFFFFF, 0, 0, 0));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 1));
    // Restart with zero loudness.
    directed_ticks.push_back(make_row(1, 24'd3000000, 24'hFFFFFF, 0, 4, 1, 0, 1));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 1));
    // Loud notes that swing to both rails.
    directed_ticks.push_back(make_row(1, 24'd6291456, 24'hFFF000, 16'hFFFF, 6, 0, 0, 0));
    for (int i = 0; i < 4; i++) begin
      directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0));
    end
    directed_ticks.push_back(make_row(1, 24'd2796203, 24'hFFFFFF, 16'd40000, 3, 0, 0, 0));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 0, 0, 0));
    directed_ticks.push_back(make_row(1, 1, 1, 1, 1, 0, 0, 0));
    directed_ticks.push_back(make_row(0, 0, 0, 0, 0, 1, 0, 0));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_ticks[i]) begin
      send_request(directed_ticks[i]);
    end

    while (n_items < RANDOM_ITEMS) begin
      if (n_items >= RANDOM_ITEMS - CALM_TAIL) begin
        calm = 1'b1;
      end
      if (n_items >= RANDOM_ITEMS / 2 && !drained) begin
        drain_voice();
        drained = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        r = random_row(1'b1);
        send_request(r);
        ticks = (r.dur == 0) ? 0 : int'(r.dur) - 1;
        if (ticks > 60) begin
          ticks = $urandom_range(10, 60);
        end else begin
          ticks = ticks + $urandom_range(0, 2);
        end
        repeat (ticks) send_request(random_row(1'b0));
      end else begin
        repeat ($urandom_range(1, 4)) send_request(random_row($urandom_range(0, 1) == 1));
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d samples from %0d note starts: %0d sounding, %0d at full scale",
             n_checked, n_starts, n_sounding, n_clipped);
    $display("Input and output stalls were random until the last %0d ticks", CALM_TAIL);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/adhv_pkg.sv
rtl/adhv_sine_rom.sv
rtl/adhv_seq.sv
rtl/adhv_dp.sv
rtl/additive_decaying_harmonic_voice_top.sv
sim/additive_decaying_harmonic_voice_top_tb.sv
